>>> rtl/test_pattern_pixel_generator_defines.svh
// Assertion macros used by the test pattern pixel generator top level.
`ifndef TEST_PATTERN_PIXEL_GENERATOR_DEFINES_SVH
`define TEST_PATTERN_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define TPPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent holds one pipeline latency after the antecedent.
`define TPPG_ASSERT_LAT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##PIPE_LAT (cons)) else $error(msg);

`endif

>>> rtl/tppg_pkg.sv
// Package with types, constants and helper functions of the test pattern pixel generator.
package tppg_pkg;

  // Field and register widths.
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int PITCH_W  = 16;
  localparam int FMT_W    = 3;
  localparam int NB_W     = 3;
  localparam int OFF_W    = 28;
  localparam int PIX_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Divider widths: numerator is coord * 255, quotient is one color byte.
  localparam int NUM_W = 20;
  localparam int DIV_W = 12;
  localparam int QUO_W = 8;

  // Cycles from an accepted item to its result strobe.
  localparam int PIPE_LAT = 7;

  // Largest frame dimension; larger register values saturate here.
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SELECT = 3'd4;

  // Register reset values.
  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH    = 13'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT   = 13'd480;
  localparam logic [PITCH_W-1:0] RST_ROW_PITCH      = 16'd2560;
  localparam logic [FMT_W-1:0]   RST_PIXEL_FORMAT   = 3'd4;
  localparam logic               RST_PATTERN_SELECT = 1'b0;

  // Pixel format codes; codes above BGRX behave as BGRX.
  localparam logic [FMT_W-1:0] FMT_RGB332 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGB555 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_BGR24  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_BGRX32 = 3'd4;

  // Pattern constants.
  localparam logic [7:0] CHECK_HI  = 8'hE0;
  localparam logic [7:0] CHECK_LO  = 8'h20;
  localparam logic [7:0] MIX_R_MUL = 8'd37;
  localparam logic [7:0] MIX_G_MUL = 8'd67;
  localparam logic [7:0] MIX_B_MUL = 8'd97;

  // Reciprocals for x / 31 and y / 23, exact for 12-bit coordinates.
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 18;
  localparam logic [RECIP_W-1:0] RECIP_31 = 14'd8457;
  localparam logic [RECIP_W-1:0] RECIP_23 = 14'd11398;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PITCH   = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  // Values that ride along the divider stages.
  typedef struct packed {
    logic [7:0]       mix_r;
    logic [7:0]       mix_g;
    logic [7:0]       mix_b;
    logic             chk;
    status_t          st;
    logic [OFF_W-1:0] off;
  } side_t;

  // Bytes per pixel of a format code.
  function automatic logic [NB_W-1:0] bytes_for_format(input logic [FMT_W-1:0] fmt);
    logic [NB_W-1:0] nb;
    case (fmt)
      FMT_RGB332: nb = 3'd1;
      FMT_RGB555: nb = 3'd2;
      FMT_RGB565: nb = 3'd2;
      FMT_BGR24:  nb = 3'd3;
      default:    nb = 3'd4;
    endcase
    return nb;
  endfunction

  // Pack an RGB triple into the frame-buffer format, byte 0 in bits 7:0.
  function automatic logic [PIX_W-1:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b,
                                                  input logic [FMT_W-1:0] fmt);
    logic [PIX_W-1:0] pix;
    case (fmt)
      FMT_RGB332: pix = {24'd0, r[7:5], g[7:5], b[7:6]};
      FMT_RGB555: pix = {17'd0, r[7:3], g[7:3], b[7:3]};
      FMT_RGB565: pix = {16'd0, r[7:3], g[7:2], b[7:3]};
      default:    pix = {8'd0, r, g, b};
    endcase
    return pix;
  endfunction

endpackage

>>> rtl/tppg_div_step.sv
// Two restoring division steps that produce two quotient bits of a color gradient.
module tppg_div_step (
  input  logic [tppg_pkg::NUM_W-1:0] rem_in,
  input  logic [tppg_pkg::DIV_W-1:0] divisor,
  input  logic [1:0]                 pair_sel,
  output logic [tppg_pkg::NUM_W-1:0] rem_out,
  output logic [1:0]                 q_bits
);
  import tppg_pkg::*;

  logic [2:0]       sh_hi;
  logic [2:0]       sh_lo;
  logic [NUM_W-1:0] d_hi;
  logic [NUM_W-1:0] d_lo;
  logic [NUM_W-1:0] rem_mid;

  // The pair selects quotient bits {2*sel+1, 2*sel}.
  assign sh_hi = {pair_sel, 1'b1};
  assign sh_lo = {pair_sel, 1'b0};
  assign d_hi  = NUM_W'(divisor) << sh_hi;
  assign d_lo  = NUM_W'(divisor) << sh_lo;

  // Upper bit, then lower bit: subtract the shifted divisor when it fits.
  always_comb begin
    q_bits[1] = (rem_in >= d_hi);
    rem_mid   = q_bits[1] ? (rem_in - d_hi) : rem_in;
    q_bits[0] = (rem_mid >= d_lo);
    rem_out   = q_bits[0] ? (rem_mid - d_lo) : rem_mid;
  end

endmodule

>>> rtl/test_pattern_pixel_generator.sv
// Top level of the test pattern pixel generator: config registers and the pixel pipeline.
//
// Usage: write frame_width, frame_height, row_pitch, pixel_format and
// pattern_select through the cfg_ port (cfg_ready is always high) while no
// item is in flight. Then pulse start with a pixel coordinate on in_x_coord
// and in_y_coord; an item is taken on every edge where start is high and busy
// is low, so one pixel can enter each clock.
// Each item produces exactly one result: out_valid is high for one cycle with
// the packed pixel, its byte count, its byte offset (y * pitch + x * bytes)
// and a status code. Throughput is one item per cycle. The depth is set by
// the gradient divider, which resolves two quotient bits per stage over four
// stages, plus an input stage, a multiply/status stage and the packing/output
// stage.
// The receiver cannot stall; results are presented once and never held.
// Synchronous reset clears the pipeline valid bits and loads the register
// defaults (640 x 480, pitch 2560, 32-bit BGRX, gradient pattern); busy is
// high during reset and is registered low once rst_n is sampled high.
`include "test_pattern_pixel_generator_defines.svh"

module test_pattern_pixel_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tppg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tppg_pkg::CFG_DAT_W-1:0] cfg_data,
  // Input item channel.
  input  logic                           start,
  output logic                           busy,
  input  logic [tppg_pkg::COORD_W-1:0]   in_x_coord,
  input  logic [tppg_pkg::COORD_W-1:0]   in_y_coord,
  // Result channel.
  output logic                           out_valid,
  output logic [tppg_pkg::PIX_W-1:0]     out_pixel_value,
  output logic [tppg_pkg::NB_W-1:0]      out_byte_count,
  output logic [tppg_pkg::OFF_W-1:0]     out_byte_offset,
  output logic [1:0]                     out_status
);
  import tppg_pkg::*;

  // Configuration registers.
  logic [DIM_W-1:0]   frame_width_r;
  logic [DIM_W-1:0]   frame_height_r;
  logic [PITCH_W-1:0] row_pitch_r;
  logic [FMT_W-1:0]   pixel_format_r;
  logic               pattern_select_r;
  logic               busy_r;

  // Derived configuration values.
  logic [DIM_W-1:0]   w_cl;
  logic [DIM_W-1:0]   h_cl;
  logic [DIV_W-1:0]   div_w;
  logic [DIV_W-1:0]   div_h;
  logic [NB_W-1:0]    nb;
  logic               pitch_narrow;

  logic               in_fire;
  logic [6:0]         vld_r;

  // Stage 0: captured coordinates.
  logic [COORD_W-1:0] x0_r;
  logic [COORD_W-1:0] y0_r;

  // Stage 1: numerators, tile index, products and status.
  logic [COORD_W-1:0] x1_r;
  logic [COORD_W-1:0] y1_r;
  logic [2:0]         tile1_r;
  logic [OFF_W-1:0]   prod_y1_r;
  logic [14:0]        prod_x1_r;
  status_t            st1_r;
  logic [25:0]        x_recip;
  logic [25:0]        y_recip;
  logic [2:0]         tile_nxt;
  status_t            st_nxt;

  // Divider remainders of stages 1..5, quotients and side data of stages 2..5.
  logic [NUM_W-1:0]   remr_r [1:5];
  logic [NUM_W-1:0]   remg_r [1:5];
  logic [QUO_W-1:0]   qr_r   [2:5];
  logic [QUO_W-1:0]   qg_r   [2:5];
  side_t              side_r [2:5];
  side_t              side_nxt;

  // Output stage.
  logic [7:0]         col_r;
  logic [7:0]         col_g;
  logic [7:0]         col_b;
  logic [PIX_W-1:0]   pix_nxt;
  logic [PIX_W-1:0]   out_pix_r;
  logic [NB_W-1:0]    out_nb_r;
  logic [OFF_W-1:0]   out_off_r;
  logic [1:0]         out_st_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign in_fire   = start && !busy_r;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= RST_FRAME_WIDTH;
      frame_height_r   <= RST_FRAME_HEIGHT;
      row_pitch_r      <= RST_ROW_PITCH;
      pixel_format_r   <= RST_PIXEL_FORMAT;
      pattern_select_r <= RST_PATTERN_SELECT;
      busy_r           <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:    frame_width_r    <= cfg_data[DIM_W-1:0];
          CFG_FRAME_HEIGHT:   frame_height_r   <= cfg_data[DIM_W-1:0];
          CFG_ROW_PITCH:      row_pitch_r      <= cfg_data;
          CFG_PIXEL_FORMAT:   pixel_format_r   <= cfg_data[FMT_W-1:0];
          CFG_PATTERN_SELECT: pattern_select_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Saturated dims, gradient divisors; user holds stable while items in flight; unenforced.
  assign w_cl         = (frame_width_r > MAX_DIM) ? MAX_DIM : frame_width_r;
  assign h_cl         = (frame_height_r > MAX_DIM) ? MAX_DIM : frame_height_r;
  assign div_w        = DIV_W'(w_cl - 13'd1);
  assign div_h        = DIV_W'(h_cl - 13'd1);
  assign nb           = bytes_for_format(pixel_format_r);
  assign pitch_narrow = row_pitch_r < (16'(w_cl) * 16'(nb));

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_fire};
    end
  end

  // Stage 0: capture the coordinate.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x0_r <= in_x_coord;
      y0_r <= in_y_coord;
    end
  end

  // Stage 1: tile index by reciprocal multiply, status, offset products and gradient numerators.
  assign x_recip  = 26'(x0_r) * 26'(RECIP_31);
  assign y_recip  = 26'(y0_r) * 26'(RECIP_23);
  assign tile_nxt = x_recip[RECIP_SHIFT+2:RECIP_SHIFT] + y_recip[RECIP_SHIFT+2:RECIP_SHIFT];

  always_comb begin
    if (pitch_narrow) begin
      st_nxt = ST_PITCH;
    end else if (({1'b0, x0_r} >= w_cl) || ({1'b0, y0_r} >= h_cl)) begin
      st_nxt = ST_OUTSIDE;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    x1_r      <= x0_r;
    y1_r      <= y0_r;
    tile1_r   <= tile_nxt;
    st1_r     <= st_nxt;
    prod_y1_r <= OFF_W'(y0_r) * OFF_W'(row_pitch_r);
    prod_x1_r <= 15'(x0_r) * 15'(nb);
    remr_r[1] <= NUM_W'({x0_r, 8'h00}) - NUM_W'(x0_r);
    remg_r[1] <= NUM_W'({y0_r, 8'h00}) - NUM_W'(y0_r);
  end

  // Stage 2 side data: color mix channels, checker bit, status and byte offset.
  always_comb begin
    side_nxt.mix_r = 8'(tile1_r) * MIX_R_MUL + x1_r[7:0];
    side_nxt.mix_g = 8'(tile1_r) * MIX_G_MUL + y1_r[7:0];
    side_nxt.mix_b = 8'(tile1_r) * MIX_B_MUL + x1_r[7:0] + y1_r[7:0];
    side_nxt.chk   = x1_r[4] ^ y1_r[4];
    side_nxt.st    = st1_r;
    side_nxt.off   = prod_y1_r + OFF_W'(prod_x1_r);
  end

  always_ff @(posedge clk) begin
    side_r[2] <= side_nxt;
  end

  // Stages 2..5: two gradient quotient bits per stage, most significant first.
  for (genvar j = 2; j <= 5; j++) begin : g_div
    logic [NUM_W-1:0] remr_nxt;
    logic [NUM_W-1:0] remg_nxt;
    logic [1:0]       qr_bits;
    logic [1:0]       qg_bits;
    logic [QUO_W-1:0] qr_prev;
    logic [QUO_W-1:0] qg_prev;

    tppg_div_step u_div_r (
      .rem_in   (remr_r[j-1]),
      .divisor  (div_w),
      .pair_sel (2'(5 - j)),
      .rem_out  (remr_nxt),
      .q_bits   (qr_bits)
    );

    tppg_div_step u_div_g (
      .rem_in   (remg_r[j-1]),
      .divisor  (div_h),
      .pair_sel (2'(5 - j)),
      .rem_out  (remg_nxt),
      .q_bits   (qg_bits)
    );

    if (j == 2) begin : g_first
      assign qr_prev = '0;
      assign qg_prev = '0;
    end else begin : g_next
      assign qr_prev = qr_r[j-1];
      assign qg_prev = qg_r[j-1];

      always_ff @(posedge clk) begin
        side_r[j] <= side_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      remr_r[j] <= remr_nxt;
      remg_r[j] <= remg_nxt;
      qr_r[j]   <= {qr_prev[QUO_W-3:0], qr_bits};
      qg_r[j]   <= {qg_prev[QUO_W-3:0], qg_bits};
    end
  end

  // Output stage: pick the pattern, pack it, and zero it on a bad status.
  always_comb begin
    if (pattern_select_r) begin
      col_r = side_r[5].mix_r;
      col_g = side_r[5].mix_g;
      col_b = side_r[5].mix_b;
    end else begin
      col_r = (w_cl > 13'd1) ? qr_r[5] : 8'd0;
      col_g = (h_cl > 13'd1) ? qg_r[5] : 8'd0;
      col_b = side_r[5].chk ? CHECK_HI : CHECK_LO;
    end
    pix_nxt = (side_r[5].st == ST_OK) ? pack_pixel(col_r, col_g, col_b, pixel_format_r) : '0;
  end

  always_ff @(posedge clk) begin
    out_pix_r <= pix_nxt;
    out_nb_r  <= nb;
    out_off_r <= side_r[5].off;
    out_st_r  <= side_r[5].st;
  end

  assign out_valid       = vld_r[6];
  assign out_pixel_value = out_pix_r;
  assign out_byte_count  = out_nb_r;
  assign out_byte_offset = out_off_r;
  assign out_status      = out_st_r;

  // Every accepted item gives its result strobe after the pipeline latency.
  `TPPG_ASSERT_LAT(a_item_latency, in_fire, out_valid, "accepted item produced no result")
  // A pixel that failed the pitch or frame check is all zero.
  `TPPG_ASSERT_IMP(a_bad_status_zero, out_valid && (out_status != ST_OK),
                   out_pixel_value == '0, "nonzero pixel with bad status")
  // The byte count is between one and four.
  `TPPG_ASSERT_IMP(a_byte_count_range, out_valid,
                   (out_byte_count != 3'd0) && (out_byte_count <= 3'd4),
                   "byte count out of range")
  // For a one-byte pixel, the bytes above byte 0 are zero.
  `TPPG_ASSERT_IMP(a_unused_bytes_zero, out_valid && (out_byte_count == 3'd1),
                   out_pixel_value[31:8] == '0, "unused pixel bytes not zero")

endmodule
